FILE: sv/au_audio_stream_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// au_audio_stream_decoder_top_defines.svh
// Assertion macros shared by the audio stream decoder modules.
// ----------------------------------------------------------------------------
`ifndef AU_AUDIO_STREAM_DECODER_TOP_DEFINES_SVH
`define AU_AUDIO_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define AU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define AU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define AU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AU_ASSERT_ALWAYS(lbl, expr, msg)

`define AU_ASSERT_IMPLY(lbl, ante, cons, msg)

`define AU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/au_asd_pkg.sv
// ----------------------------------------------------------------------------
// au_asd_pkg
// Types and codes shared by the audio stream decoder modules.
// ----------------------------------------------------------------------------
package au_asd_pkg;

  localparam logic [1:0] ENC_ULAW  = 2'd1;
  localparam logic [1:0] ENC_LIN8  = 2'd2;
  localparam logic [1:0] ENC_LIN16 = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DRAIN  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_ENCODING  = 3'd2,
    ERR_CHANNELS  = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_t;

  typedef struct packed {
    logic        has_hdr;
    logic        has_smp;
    logic        has_tail;
    err_t        err;
    logic [31:0] rate;
    logic [1:0]  chans;
    logic [4:0]  bits;
    logic [31:0] length;
    logic [1:0]  mode;
    logic [15:0] raw;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    logic [1:0]         channel_count;
    logic [4:0]         sample_bits;
    logic [31:0]        data_length;
    err_t               error_code;
    logic               is_last;
  } result_t;

endpackage

FILE: sv/au_asd_fifo.sv
// ----------------------------------------------------------------------------
// au_asd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module au_asd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: sv/au_asd_front.sv
// ----------------------------------------------------------------------------
// au_asd_front
// Header parser and byte classifier; issues one command per productive byte.
// ----------------------------------------------------------------------------
`include "au_audio_stream_decoder_top_defines.svh"

module au_asd_front import au_asd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       cmd_push,
  output cmd_t       cmd
);

  localparam logic [31:0] MAGIC        = 32'h2E736E64;
  localparam logic [2:0]  FLD_OFFSET   = 3'd1;
  localparam logic [2:0]  FLD_LENGTH   = 3'd2;
  localparam logic [2:0]  FLD_ENCODING = 3'd3;
  localparam logic [2:0]  FLD_RATE     = 3'd4;
  localparam logic [2:0]  FLD_CHANNELS = 3'd5;

  phase_t      phase_r, phase_nxt, phase_step;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] consumed_r, consumed_nxt, consumed_inc;
  logic [23:0] gather_r, gather_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] count_r, count_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [7:0]  hi_r, hi_nxt;

  logic [31:0] word;
  logic [2:0]  field;
  logic        is_hdr, in_magic, word_end, hdr_word;
  logic        enc_ok, chan_ok;
  logic        bad_magic, bad_enc, bad_chan, any_err;
  logic        hdr_done, hdr_empty, data_hit, data_done, smp, finish, trunc;
  err_t        err_code;

  assign word         = {gather_r, data_byte};
  assign field        = pos_r[4:2];
  assign is_hdr       = (phase_r == PH_HEADER);
  assign in_magic     = (pos_r[31:2] == '0);
  assign word_end     = !in_magic && (pos_r[1:0] == 2'd3);
  assign hdr_word     = is_hdr && word_end;
  assign enc_ok       = (word == {30'd0, ENC_ULAW}) || (word == {30'd0, ENC_LIN8}) ||
                        (word == {30'd0, ENC_LIN16});
  assign chan_ok      = (word == 32'd1) || (word == 32'd2);
  assign bad_magic    = is_hdr && in_magic &&
                        (data_byte != MAGIC[{~pos_r[1:0], 3'b000} +: 8]);
  assign bad_enc      = hdr_word && (field == FLD_ENCODING) && !enc_ok;
  assign bad_chan     = hdr_word && (field == FLD_CHANNELS) && !chan_ok;
  assign any_err      = bad_magic || bad_enc || bad_chan;
  assign hdr_done     = hdr_word && (field == FLD_CHANNELS) && chan_ok;
  assign hdr_empty    = hdr_done && (count_r == '0);
  assign consumed_inc = consumed_r + 32'd1;
  assign data_hit     = (phase_r == PH_BODY) && (pos_r >= offset_r);
  assign data_done    = data_hit && (consumed_inc == count_r);
  assign smp          = data_hit && ((mode_r != ENC_LIN16) || consumed_r[0]);
  assign finish       = hdr_empty || data_done;

  // phase after this byte, before the end-of-file check
  always_comb begin
    phase_step = phase_r;
    if (finish || any_err) begin
      phase_step = PH_DRAIN;
    end else if (hdr_done) begin
      phase_step = PH_BODY;
    end
  end

  assign trunc = last_byte && (phase_step != PH_DRAIN);

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (last_byte) begin
        phase_nxt = PH_HEADER;
      end else begin
        phase_nxt = phase_step;
      end
    end
  end

  always_comb begin
    if (bad_magic) begin
      err_code = ERR_MAGIC;
    end else if (bad_enc) begin
      err_code = ERR_ENCODING;
    end else if (bad_chan) begin
      err_code = ERR_CHANNELS;
    end else if (trunc) begin
      err_code = ERR_TRUNCATED;
    end else begin
      err_code = ERR_NONE;
    end
  end

  always_comb begin
    cmd.has_hdr  = hdr_done;
    cmd.has_smp  = smp;
    cmd.has_tail = finish || any_err || trunc;
    cmd.err      = err_code;
    cmd.rate     = rate_r;
    cmd.chans    = word[1:0];
    cmd.bits     = (mode_r == ENC_LIN8) ? 5'd8 : 5'd16;
    cmd.length   = count_r;
    cmd.mode     = mode_r;
    cmd.raw      = {hi_r, data_byte};
    cmd_push     = take && (hdr_done || smp || cmd.has_tail);
  end

  always_comb begin
    pos_nxt      = pos_r;
    consumed_nxt = consumed_r;
    gather_nxt   = gather_r;
    offset_nxt   = offset_r;
    count_nxt    = count_r;
    mode_nxt     = mode_r;
    rate_nxt     = rate_r;
    hi_nxt       = hi_r;
    if (take) begin
      pos_nxt = (&pos_r) ? pos_r : pos_r + 32'd1;
      if (is_hdr && !in_magic) begin
        gather_nxt = word[23:0];
      end
      if (hdr_word) begin
        unique case (field)
          FLD_OFFSET:   offset_nxt = word;
          FLD_LENGTH:   count_nxt  = word;
          FLD_ENCODING: begin
            if (enc_ok) begin
              mode_nxt = word[1:0];
            end
          end
          FLD_RATE:     rate_nxt   = word;
          default:      ;
        endcase
      end
      if (data_hit) begin
        consumed_nxt = consumed_inc;
        if ((mode_r == ENC_LIN16) && !consumed_r[0]) begin
          hi_nxt = data_byte;
        end
      end
      if (last_byte) begin
        pos_nxt      = '0;
        consumed_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      consumed_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      consumed_r <= consumed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gather_r <= gather_nxt;
    offset_r <= offset_nxt;
    count_r  <= count_nxt;
    mode_r   <= mode_nxt;
    rate_r   <= rate_nxt;
    hi_r     <= hi_nxt;
  end

  `AU_ASSERT_IMPLY(a_hdr_smp_excl, cmd_push, !(cmd.has_hdr && cmd.has_smp), "header and sample in one command")
  `AU_ASSERT_NEXT(a_last_restart, take && last_byte, (pos_r == '0) && (consumed_r == '0) && (phase_r == PH_HEADER), "parser not restarted after final byte")
  `AU_ASSERT_IMPLY(a_hdr_pos_range, phase_r == PH_HEADER, pos_r < 32'd24, "header phase past header end")

endmodule

FILE: sv/au_asd_back.sv
// ----------------------------------------------------------------------------
// au_asd_back
// Command executor: sample decode and expansion into result transactions.
// ----------------------------------------------------------------------------
`include "au_audio_stream_decoder_top_defines.svh"

module au_asd_back import au_asd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  input  logic    out_full,
  output logic    out_push,
  output result_t res
);

  function automatic logic [15:0] mulaw_expand(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] mag;
    u   = ~code;
    mag = (({9'd0, u[3:0], 3'b000} + 16'h0084) << u[6:4]) - 16'h0084;
    return u[7] ? (16'h0000 - mag) : mag;
  endfunction

  logic        sel_r, sel_nxt;
  logic        go, take_tail;
  logic [7:0]  lin8;
  logic [15:0] smp_val;

  assign go        = !cmd_empty && !out_full;
  assign take_tail = sel_r || !(cmd.has_hdr || cmd.has_smp);
  assign out_push  = go;
  assign cmd_pop   = go && (take_tail || !cmd.has_tail);
  assign lin8      = cmd.raw[7:0] ^ 8'h80;

  always_comb begin
    case (cmd.mode)
      ENC_LIN8:  smp_val = {{8{lin8[7]}}, lin8};
      ENC_LIN16: smp_val = cmd.raw;
      default:   smp_val = mulaw_expand(cmd.raw[7:0]);
    endcase
  end

  always_comb begin
    res = '0;
    if (take_tail) begin
      if (cmd.err == ERR_NONE) begin
        res.kind = KIND_DONE;
      end else begin
        res.kind = KIND_ERROR;
      end
      res.error_code = cmd.err;
      res.is_last    = 1'b1;
    end else if (cmd.has_hdr) begin
      res.kind          = KIND_HEADER;
      res.sample_rate   = cmd.rate;
      res.channel_count = cmd.chans;
      res.sample_bits   = cmd.bits;
      res.data_length   = cmd.length;
    end else begin
      res.kind   = KIND_SAMPLE;
      res.sample = smp_val;
    end
  end

  always_comb begin
    sel_nxt = sel_r;
    if (go) begin
      sel_nxt = !cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  `AU_ASSERT_IMPLY(a_sel_has_pair, sel_r, !cmd_empty && cmd.has_tail && (cmd.has_hdr || cmd.has_smp), "second result without a paired command")
  `AU_ASSERT_IMPLY(a_pop_with_push, cmd_pop, out_push, "command dropped without a result")
  `AU_ASSERT_IMPLY(a_no_idle_cmd, !cmd_empty, cmd.has_hdr || cmd.has_smp || cmd.has_tail, "queued command yields nothing")
  `AU_ASSERT_NEXT(a_sel_hold, sel_r && !out_push, sel_r, "pending second result lost on stall")

endmodule

FILE: sv/au_audio_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// au_audio_stream_decoder_top
// AU stream decoder: header parse, then linear or mu-law sample output.
// ----------------------------------------------------------------------------
// Channel   Handshake     Payload
// input     push / full   in_data_byte, in_last_byte
// result    pop / empty   out_kind .. out_is_last
//
// One byte is accepted per cycle while the command queue has room.
// The back end writes one result per cycle while a command is queued and the
// result queue has room; a byte that yields two results holds its command until
// both are written. Commands and results each pass through a queue.
// Reset is synchronous and clears both queues and the parser.
// With pop low the result queue fills, then the command queue, then full rises.
// ----------------------------------------------------------------------------
module au_audio_stream_decoder_top import au_asd_pkg::*; #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_sample,
  output logic [31:0]        out_sample_rate,
  output logic [1:0]         out_channel_count,
  output logic [4:0]         out_sample_bits,
  output logic [31:0]        out_data_length,
  output logic [2:0]         out_error_code,
  output logic               out_is_last
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  logic       take;
  logic       cmd_push, cmd_pop, cmd_empty, res_push, res_full;
  cmd_t       cmd_in, cmd_out;
  result_t    res_in, res_out;
  logic [CMD_W-1:0] cmd_dout;
  logic [RES_W-1:0] res_dout;

  assign take    = push && !full;
  assign cmd_out = cmd_t'(cmd_dout);
  assign res_out = result_t'(res_dout);

  au_asd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  au_asd_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  au_asd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .res       (res_in)
  );

  au_asd_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_kind          = res_out.kind;
  assign out_sample        = res_out.sample;
  assign out_sample_rate   = res_out.sample_rate;
  assign out_channel_count = res_out.channel_count;
  assign out_sample_bits   = res_out.sample_bits;
  assign out_data_length   = res_out.data_length;
  assign out_error_code    = res_out.error_code;
  assign out_is_last       = res_out.is_last;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the AU stream decoder. Short hand-built files and then
// random files, mostly well formed, go in one byte per transaction.
// A scoreboard predicts header reports, samples, end and error results and
// checks every popped result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package au_decode_tb_pkg;
  import au_asd_pkg::*;

  localparam logic [31:0] AU_MAGIC = 32'h2E73_6E64;

  class au_decode_scoreboard;
    result_t     predicted_results[$];
    int unsigned mismatches;

    logic [31:0] byte_pos;
    logic [31:0] word_acc;
    logic [31:0] data_start;
    logic [31:0] data_len;
    logic [31:0] rate_word;
    logic [31:0] consumed;
    logic [1:0]  enc_mode;
    logic [1:0]  chan_word;
    logic [7:0]  high_byte;
    phase_t      phase;
    int          results_this_byte;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      byte_pos   = '0;
      word_acc   = '0;
      data_start = '0;
      data_len   = '0;
      rate_word  = '0;
      consumed   = '0;
      enc_mode   = '0;
      chan_word  = '0;
      high_byte  = '0;
      phase      = PH_HEADER;
    endfunction

    function void add_result(kind_t k, logic [15:0] smp, logic [31:0] rate,
                             logic [1:0] ch, logic [4:0] bits, logic [31:0] len,
                             err_t e);
      result_t r;
      r.kind          = k;
      r.sample        = smp;
      r.sample_rate   = rate;
      r.channel_count = ch;
      r.sample_bits   = bits;
      r.data_length   = len;
      r.error_code    = e;
      r.is_last       = (k == KIND_DONE) || (k == KIND_ERROR);
      predicted_results.push_back(r);
      results_this_byte++;
    endfunction

    function logic [15:0] mulaw_to_linear(logic [7:0] code);
      logic [7:0]  inv;
      logic [31:0] mag;
      logic [31:0] neg;
      inv = ~code;
      mag = (({28'd0, inv[3:0]} << 3) + 32'h84) << inv[6:4];
      mag = mag - 32'h84;
      neg = 32'd0 - mag;
      return inv[7] ? neg[15:0] : mag[15:0];
    endfunction

    function void add_sample(logic [15:0] smp);
      add_result(KIND_SAMPLE, smp, '0, '0, '0, '0, ERR_NONE);
    endfunction

    function void note_byte(logic [7:0] b, logic last_in);
      logic [31:0] pos;
      logic [31:0] field_pos;
      logic [31:0] w;
      err_t        err;
      pos = byte_pos;
      err = ERR_NONE;
      results_this_byte = 0;
      if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;

      if (phase == PH_HEADER) begin
        if (pos < 32'd4) begin
          if (b != AU_MAGIC[8 * (3 - pos[1:0]) +: 8]) err = ERR_MAGIC;
        end else begin
          word_acc = {word_acc[23:0], b};
          w = word_acc;
          field_pos = pos - 32'd4;
          if (field_pos[1:0] == 2'd3) begin
            case (field_pos[31:2])
              30'd0: data_start = w;
              30'd1: data_len = w;
              30'd2: begin
                if (w != ENC_ULAW && w != ENC_LIN8 && w != ENC_LIN16) err = ERR_ENCODING;
                else enc_mode = w[1:0];
              end
              30'd3: rate_word = w;
              default: begin
                if (w != 32'd1 && w != 32'd2) begin
                  err = ERR_CHANNELS;
                end else begin
                  chan_word = w[1:0];
                  add_result(KIND_HEADER, '0, rate_word, chan_word,
                             (enc_mode == ENC_LIN8) ? 5'd8 : 5'd16, data_len, ERR_NONE);
                  if (data_len == 32'd0) begin
                    add_result(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE);
                    phase = PH_DRAIN;
                  end else begin
                    phase = PH_BODY;
                  end
                end
              end
            endcase
          end
        end
      end else if (phase == PH_BODY) begin
        if (pos >= data_start) begin
          case (enc_mode)
            ENC_LIN8: add_sample({{8{~b[7]}}, ~b[7], b[6:0]});
            ENC_LIN16: begin
              if (!consumed[0]) high_byte = b;
              else add_sample({high_byte, b});
            end
            default: add_sample(mulaw_to_linear(b));
          endcase
          consumed = consumed + 32'd1;
          if (consumed == data_len) begin
            add_result(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE);
            phase = PH_DRAIN;
          end
        end
      end

      if (err != ERR_NONE) begin
        add_result(KIND_ERROR, '0, '0, '0, '0, '0, err);
        phase = PH_DRAIN;
      end

      if (last_in) begin
        if (phase != PH_DRAIN && results_this_byte < 2)
          add_result(KIND_ERROR, '0, '0, '0, '0, '0, ERR_TRUNCATED);
        clear_state();
      end
    endfunction

    function string describe(result_t r);
      return $sformatf("kind=%0d sample=%0d rate=%08h ch=%0d bits=%0d len=%08h err=%0d last=%0b",
                       r.kind, r.sample, r.sample_rate, r.channel_count, r.sample_bits,
                       r.data_length, r.error_code, r.is_last);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = predicted_results.pop_front();
      if (got.kind !== want.kind || got.sample !== want.sample ||
          got.sample_rate !== want.sample_rate || got.channel_count !== want.channel_count ||
          got.sample_bits !== want.sample_bits || got.data_length !== want.data_length ||
          got.error_code !== want.error_code || got.is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction
  endclass

endpackage

module tb;
  import au_asd_pkg::*;
  import au_decode_tb_pkg::*;

  localparam int RANDOM_BYTES   = 1630;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_RARE, POP_PERIODIC} pop_pattern_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         in_data_byte = 8'd0;
  logic               in_last_byte = 1'b0;
  logic               pop = 1'b0;
  logic               empty;
  logic [1:0]         out_kind;
  logic signed [15:0] out_sample;
  logic [31:0]        out_sample_rate;
  logic [1:0]         out_channel_count;
  logic [4:0]         out_sample_bits;
  logic [31:0]        out_data_length;
  logic [2:0]         out_error_code;
  logic               out_is_last;

  au_decode_scoreboard sb = new();
  logic [7:0]          file_bytes[$];
  int                  bytes_sent = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  pop_pattern_t        pop_pattern = POP_ALWAYS;
  int                  pattern_left = 0;

  au_audio_stream_decoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .pop               (pop),
    .empty             (empty),
    .out_kind          (out_kind),
    .out_sample        (out_sample),
    .out_sample_rate   (out_sample_rate),
    .out_channel_count (out_channel_count),
    .out_sample_bits   (out_sample_bits),
    .out_data_length   (out_data_length),
    .out_error_code    (out_error_code),
    .out_is_last       (out_is_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && push && !full) sb.note_byte(in_data_byte, in_last_byte);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && pop && !empty) begin
      got.kind          = kind_t'(out_kind);
      got.sample        = out_sample;
      got.sample_rate   = out_sample_rate;
      got.channel_count = out_channel_count;
      got.sample_bits   = out_sample_bits;
      got.data_length   = out_data_length;
      got.error_code    = err_t'(out_error_code);
      got.is_last       = out_is_last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pop_pattern  = pop_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      case (pop_pattern)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_RARE:   pop <= ($urandom_range(0, 3) == 0);
        default:    pop <= (pattern_left % 7) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last_in);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    burst_left--;
    push         <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last_in;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    bytes_sent += file_bytes.size();
  endtask

  function automatic void add_word(logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endfunction

  function automatic void build_random_file();
    int          sel;
    int          skip;
    int          data_n;
    int          cut;
    int          idx;
    logic [31:0] offset_w;
    logic [31:0] length_w;
    logic [31:0] enc_w;
    logic [31:0] rate_w;
    logic [31:0] chan_w;
    file_bytes.delete();
    add_word(AU_MAGIC);
    if ($urandom_range(0, 19) == 0) begin
      idx = $urandom_range(0, 3);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
    end

    sel = $urandom_range(0, 9);
    offset_w = (sel < 6) ? $urandom_range(0, 40) : (sel == 6) ? 32'd0 :
               (sel == 7) ? 32'd24 : (sel == 8) ? 32'hFFFF_FFFF : $urandom;
    sel = $urandom_range(0, 9);
    length_w = (sel < 7) ? $urandom_range(1, 48) : (sel == 7) ? 32'd0 :
               (sel == 8) ? 32'hFFFF_FFFF : $urandom;
    sel = $urandom_range(0, 17);
    enc_w = (sel < 15) ? $urandom_range(1, 3) : (sel == 15) ? 32'd0 :
            (sel == 16) ? 32'd4 : $urandom;
    sel = $urandom_range(0, 9);
    rate_w = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    sel = $urandom_range(0, 16);
    chan_w = (sel < 14) ? $urandom_range(1, 2) : (sel == 14) ? 32'd0 :
             (sel == 15) ? 32'd3 : $urandom;
    add_word(offset_w);
    add_word(length_w);
    add_word(enc_w);
    add_word(rate_w);
    add_word(chan_w);

    skip = 0;
    if (offset_w > 32'd24)
      skip = (offset_w - 32'd24 > 32'd24) ? $urandom_range(0, 24) : int'(offset_w - 32'd24);
    data_n = (length_w > 32'd64) ? $urandom_range(0, 40) : int'(length_w);
    repeat (skip + data_n + $urandom_range(0, 3))
      file_bytes.push_back(8'($urandom_range(0, 255)));

    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // bad magic on a one-byte file
    file_bytes = '{8'hFF};
    send_file();
    // bad magic mid-word, then a trailing byte
    file_bytes = '{8'h2E, 8'h73, 8'h00, 8'h00};
    send_file();
    // file ends inside the magic
    file_bytes = '{8'h2E};
    send_file();
    // empty data, header closed by the final byte
    file_bytes.delete();
    add_word(AU_MAGIC);
    add_word(32'd0);
    add_word(32'd0);
    add_word({30'd0, ENC_LIN8});
    add_word(32'hFFFF_FFFF);
    add_word(32'd2);
    send_file();

    while (bytes_sent < RANDOM_BYTES) begin
      build_random_file();
      send_file();
    end
    push <= 1'b0;
    @(posedge clk);

    while (sb.predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.predicted_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
